### sv/stch_pkg.sv
// types, constants and the sequencer program of the segment/triangle closest-hit block
package stch_pkg;

  localparam int COORD_WIDTH    = 32;
  localparam int FRAC_BITS      = 16;
  localparam int DIST_WIDTH     = 48;
  localparam int VAL_WIDTH      = 64;
  localparam int RF_DEPTH       = 32;
  localparam int RF_AW          = $clog2(RF_DEPTH);
  localparam int PC_WIDTH       = 7;
  localparam int CFG_IDX_WIDTH  = 3;
  localparam int CFG_DATA_WIDTH = 48;
  localparam int NUM_SEG_REGS   = 6;
  localparam int DIV_STEPS      = VAL_WIDTH + FRAC_BITS;
  localparam int CNT_WIDTH      = $clog2(DIV_STEPS);
  localparam int PROD_WIDTH     = 2 * VAL_WIDTH;
  localparam int HALF_WIDTH     = VAL_WIDTH / 2;

  localparam logic [VAL_WIDTH-1:0]  SMAX       = {1'b0, {(VAL_WIDTH-1){1'b1}}};
  localparam logic [VAL_WIDTH-1:0]  ONE_Q      = VAL_WIDTH'(1) << FRAC_BITS;
  localparam logic [DIST_WIDTH-1:0] DIST_RESET = DIST_WIDTH'(1000) << FRAC_BITS;
  localparam logic [PC_WIDTH-1:0]   UC_LAST    = 7'd121;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_START_X = 3'd0,
    CFG_START_Y = 3'd1,
    CFG_START_Z = 3'd2,
    CFG_END_X   = 3'd3,
    CFG_END_Y   = 3'd4,
    CFG_END_Z   = 3'd5,
    CFG_LIMIT   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] v0_x;
    logic signed [COORD_WIDTH-1:0] v0_y;
    logic signed [COORD_WIDTH-1:0] v0_z;
    logic signed [COORD_WIDTH-1:0] v1_x;
    logic signed [COORD_WIDTH-1:0] v1_y;
    logic signed [COORD_WIDTH-1:0] v1_z;
    logic signed [COORD_WIDTH-1:0] v2_x;
    logic signed [COORD_WIDTH-1:0] v2_y;
    logic signed [COORD_WIDTH-1:0] v2_z;
    logic                          last_tri;
  } tri_t;

  typedef struct packed {
    logic                          hit;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic [DIST_WIDTH-1:0]         min_dist_sq;
  } result_t;

  typedef enum logic [3:0] {
    OP_LD, OP_ADD, OP_SUB, OP_MUL, OP_DIV,
    OP_CHKZ, OP_CHKR, OP_CHKN, OP_CMPD, OP_SETP, OP_END
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FETCH, ST_EXEC, ST_MUL, ST_DIV, ST_WB, ST_FIN
  } state_e;

  typedef struct packed {
    op_e              op;
    logic [RF_AW-1:0] dst;
    logic [RF_AW-1:0] a;
    logic [RF_AW-1:0] b;
  } uinstr_t;

  function automatic uinstr_t mi(op_e op, logic [RF_AW-1:0] d, logic [RF_AW-1:0] a,
                                 logic [RF_AW-1:0] b);
    uinstr_t r;
    r.op  = op;
    r.dst = d;
    r.a   = a;
    r.b   = b;
    return r;
  endfunction

  // register file: 0..8 vertices, 9..11 start, 12..14 end, 15..17 ab, 18..20 ac,
  // 21..23 cb, 24..26 pa then sq, 27..29 dir, 30/31 scratch; slots are reused later
  function automatic uinstr_t ucode(logic [PC_WIDTH-1:0] pc);
    uinstr_t r;
    case (pc)
      7'd0:   r = mi(OP_LD, 5'd0, 5'd0, 5'd0);
      7'd1:   r = mi(OP_LD, 5'd1, 5'd1, 5'd0);
      7'd2:   r = mi(OP_LD, 5'd2, 5'd2, 5'd0);
      7'd3:   r = mi(OP_LD, 5'd3, 5'd3, 5'd0);
      7'd4:   r = mi(OP_LD, 5'd4, 5'd4, 5'd0);
      7'd5:   r = mi(OP_LD, 5'd5, 5'd5, 5'd0);
      7'd6:   r = mi(OP_LD, 5'd6, 5'd6, 5'd0);
      7'd7:   r = mi(OP_LD, 5'd7, 5'd7, 5'd0);
      7'd8:   r = mi(OP_LD, 5'd8, 5'd8, 5'd0);
      7'd9:   r = mi(OP_LD, 5'd9, 5'd9, 5'd0);
      7'd10:  r = mi(OP_LD, 5'd10, 5'd10, 5'd0);
      7'd11:  r = mi(OP_LD, 5'd11, 5'd11, 5'd0);
      7'd12:  r = mi(OP_LD, 5'd12, 5'd12, 5'd0);
      7'd13:  r = mi(OP_LD, 5'd13, 5'd13, 5'd0);
      7'd14:  r = mi(OP_LD, 5'd14, 5'd14, 5'd0);
      // edges, pa and dir
      7'd15:  r = mi(OP_SUB, 5'd15, 5'd3, 5'd0);
      7'd16:  r = mi(OP_SUB, 5'd16, 5'd4, 5'd1);
      7'd17:  r = mi(OP_SUB, 5'd17, 5'd5, 5'd2);
      7'd18:  r = mi(OP_SUB, 5'd18, 5'd6, 5'd0);
      7'd19:  r = mi(OP_SUB, 5'd19, 5'd7, 5'd1);
      7'd20:  r = mi(OP_SUB, 5'd20, 5'd8, 5'd2);
      7'd21:  r = mi(OP_SUB, 5'd21, 5'd6, 5'd3);
      7'd22:  r = mi(OP_SUB, 5'd22, 5'd7, 5'd4);
      7'd23:  r = mi(OP_SUB, 5'd23, 5'd8, 5'd5);
      7'd24:  r = mi(OP_SUB, 5'd24, 5'd0, 5'd9);
      7'd25:  r = mi(OP_SUB, 5'd25, 5'd1, 5'd10);
      7'd26:  r = mi(OP_SUB, 5'd26, 5'd2, 5'd11);
      7'd27:  r = mi(OP_SUB, 5'd27, 5'd12, 5'd9);
      7'd28:  r = mi(OP_SUB, 5'd28, 5'd13, 5'd10);
      7'd29:  r = mi(OP_SUB, 5'd29, 5'd14, 5'd11);
      // normal
      7'd30:  r = mi(OP_MUL, 5'd30, 5'd16, 5'd20);
      7'd31:  r = mi(OP_MUL, 5'd31, 5'd17, 5'd19);
      7'd32:  r = mi(OP_SUB, 5'd0, 5'd30, 5'd31);
      7'd33:  r = mi(OP_MUL, 5'd30, 5'd17, 5'd18);
      7'd34:  r = mi(OP_MUL, 5'd31, 5'd15, 5'd20);
      7'd35:  r = mi(OP_SUB, 5'd1, 5'd30, 5'd31);
      7'd36:  r = mi(OP_MUL, 5'd30, 5'd15, 5'd19);
      7'd37:  r = mi(OP_MUL, 5'd31, 5'd16, 5'd18);
      7'd38:  r = mi(OP_SUB, 5'd2, 5'd30, 5'd31);
      // plane numerator and denominator
      7'd39:  r = mi(OP_MUL, 5'd30, 5'd0, 5'd24);
      7'd40:  r = mi(OP_MUL, 5'd31, 5'd1, 5'd25);
      7'd41:  r = mi(OP_ADD, 5'd30, 5'd30, 5'd31);
      7'd42:  r = mi(OP_MUL, 5'd31, 5'd2, 5'd26);
      7'd43:  r = mi(OP_ADD, 5'd3, 5'd30, 5'd31);
      7'd44:  r = mi(OP_MUL, 5'd30, 5'd0, 5'd27);
      7'd45:  r = mi(OP_MUL, 5'd31, 5'd1, 5'd28);
      7'd46:  r = mi(OP_ADD, 5'd30, 5'd30, 5'd31);
      7'd47:  r = mi(OP_MUL, 5'd31, 5'd2, 5'd29);
      7'd48:  r = mi(OP_ADD, 5'd4, 5'd30, 5'd31);
      7'd49:  r = mi(OP_CHKZ, 5'd0, 5'd4, 5'd0);
      7'd50:  r = mi(OP_DIV, 5'd5, 5'd3, 5'd4);
      7'd51:  r = mi(OP_CHKR, 5'd0, 5'd5, 5'd0);
      // intersection point
      7'd52:  r = mi(OP_MUL, 5'd30, 5'd5, 5'd27);
      7'd53:  r = mi(OP_ADD, 5'd12, 5'd9, 5'd30);
      7'd54:  r = mi(OP_MUL, 5'd30, 5'd5, 5'd28);
      7'd55:  r = mi(OP_ADD, 5'd13, 5'd10, 5'd30);
      7'd56:  r = mi(OP_MUL, 5'd30, 5'd5, 5'd29);
      7'd57:  r = mi(OP_ADD, 5'd14, 5'd11, 5'd30);
      7'd58:  r = mi(OP_SUB, 5'd6, 5'd6, 5'd12);
      7'd59:  r = mi(OP_SUB, 5'd7, 5'd7, 5'd13);
      7'd60:  r = mi(OP_SUB, 5'd8, 5'd8, 5'd14);
      7'd61:  r = mi(OP_SUB, 5'd24, 5'd12, 5'd9);
      7'd62:  r = mi(OP_SUB, 5'd25, 5'd13, 5'd10);
      7'd63:  r = mi(OP_SUB, 5'd26, 5'd14, 5'd11);
      // g = cq.ab
      7'd64:  r = mi(OP_MUL, 5'd30, 5'd6, 5'd15);
      7'd65:  r = mi(OP_MUL, 5'd31, 5'd7, 5'd16);
      7'd66:  r = mi(OP_ADD, 5'd30, 5'd30, 5'd31);
      7'd67:  r = mi(OP_MUL, 5'd31, 5'd8, 5'd17);
      7'd68:  r = mi(OP_ADD, 5'd0, 5'd30, 5'd31);
      // h = cq.ac
      7'd69:  r = mi(OP_MUL, 5'd30, 5'd6, 5'd18);
      7'd70:  r = mi(OP_MUL, 5'd31, 5'd7, 5'd19);
      7'd71:  r = mi(OP_ADD, 5'd30, 5'd30, 5'd31);
      7'd72:  r = mi(OP_MUL, 5'd31, 5'd8, 5'd20);
      7'd73:  r = mi(OP_ADD, 5'd1, 5'd30, 5'd31);
      // c = ac.ab
      7'd74:  r = mi(OP_MUL, 5'd30, 5'd18, 5'd15);
      7'd75:  r = mi(OP_MUL, 5'd31, 5'd19, 5'd16);
      7'd76:  r = mi(OP_ADD, 5'd30, 5'd30, 5'd31);
      7'd77:  r = mi(OP_MUL, 5'd31, 5'd20, 5'd17);
      7'd78:  r = mi(OP_ADD, 5'd2, 5'd30, 5'd31);
      // d = cb.ab
      7'd79:  r = mi(OP_MUL, 5'd30, 5'd21, 5'd15);
      7'd80:  r = mi(OP_MUL, 5'd31, 5'd22, 5'd16);
      7'd81:  r = mi(OP_ADD, 5'd30, 5'd30, 5'd31);
      7'd82:  r = mi(OP_MUL, 5'd31, 5'd23, 5'd17);
      7'd83:  r = mi(OP_ADD, 5'd3, 5'd30, 5'd31);
      // e = ac.ac
      7'd84:  r = mi(OP_MUL, 5'd30, 5'd18, 5'd18);
      7'd85:  r = mi(OP_MUL, 5'd31, 5'd19, 5'd19);
      7'd86:  r = mi(OP_ADD, 5'd30, 5'd30, 5'd31);
      7'd87:  r = mi(OP_MUL, 5'd31, 5'd20, 5'd20);
      7'd88:  r = mi(OP_ADD, 5'd4, 5'd30, 5'd31);
      // f = cb.ac
      7'd89:  r = mi(OP_MUL, 5'd30, 5'd21, 5'd18);
      7'd90:  r = mi(OP_MUL, 5'd31, 5'd22, 5'd19);
      7'd91:  r = mi(OP_ADD, 5'd30, 5'd30, 5'd31);
      7'd92:  r = mi(OP_MUL, 5'd31, 5'd23, 5'd20);
      7'd93:  r = mi(OP_ADD, 5'd5, 5'd30, 5'd31);
      // det and barycentric weights
      7'd94:  r = mi(OP_MUL, 5'd30, 5'd2, 5'd5);
      7'd95:  r = mi(OP_MUL, 5'd31, 5'd4, 5'd3);
      7'd96:  r = mi(OP_SUB, 5'd9, 5'd30, 5'd31);
      7'd97:  r = mi(OP_CHKZ, 5'd0, 5'd9, 5'd0);
      7'd98:  r = mi(OP_MUL, 5'd30, 5'd5, 5'd0);
      7'd99:  r = mi(OP_MUL, 5'd31, 5'd3, 5'd1);
      7'd100: r = mi(OP_SUB, 5'd10, 5'd30, 5'd31);
      7'd101: r = mi(OP_DIV, 5'd10, 5'd10, 5'd9);
      7'd102: r = mi(OP_CHKN, 5'd0, 5'd10, 5'd0);
      7'd103: r = mi(OP_MUL, 5'd30, 5'd2, 5'd1);
      7'd104: r = mi(OP_MUL, 5'd31, 5'd4, 5'd0);
      7'd105: r = mi(OP_SUB, 5'd11, 5'd30, 5'd31);
      7'd106: r = mi(OP_DIV, 5'd11, 5'd11, 5'd9);
      7'd107: r = mi(OP_CHKN, 5'd0, 5'd11, 5'd0);
      7'd108: r = mi(OP_LD, 5'd30, 5'd15, 5'd0);
      7'd109: r = mi(OP_SUB, 5'd30, 5'd30, 5'd10);
      7'd110: r = mi(OP_SUB, 5'd30, 5'd30, 5'd11);
      7'd111: r = mi(OP_CHKN, 5'd0, 5'd30, 5'd0);
      // squared distance and update
      7'd112: r = mi(OP_MUL, 5'd30, 5'd24, 5'd24);
      7'd113: r = mi(OP_MUL, 5'd31, 5'd25, 5'd25);
      7'd114: r = mi(OP_ADD, 5'd30, 5'd30, 5'd31);
      7'd115: r = mi(OP_MUL, 5'd31, 5'd26, 5'd26);
      7'd116: r = mi(OP_ADD, 5'd27, 5'd30, 5'd31);
      7'd117: r = mi(OP_CMPD, 5'd0, 5'd27, 5'd0);
      7'd118: r = mi(OP_SETP, 5'd0, 5'd12, 5'd0);
      7'd119: r = mi(OP_SETP, 5'd1, 5'd13, 5'd0);
      7'd120: r = mi(OP_SETP, 5'd2, 5'd14, 5'd0);
      default: r = mi(OP_END, 5'd0, 5'd0, 5'd0);
    endcase
    return r;
  endfunction

  function automatic logic [VAL_WIDTH-1:0] mag(logic [VAL_WIDTH-1:0] a);
    return a[VAL_WIDTH-1] ? (~a + VAL_WIDTH'(1)) : a;
  endfunction

  // saturating add or subtract into [-SMAX, SMAX]
  function automatic logic [VAL_WIDTH-1:0] sat_addsub(logic [VAL_WIDTH-1:0] a,
                                                      logic [VAL_WIDTH-1:0] b,
                                                      logic sub);
    logic signed [VAL_WIDTH:0] ax;
    logic signed [VAL_WIDTH:0] bx;
    logic signed [VAL_WIDTH:0] s;
    logic signed [VAL_WIDTH:0] pmax;
    logic signed [VAL_WIDTH:0] nmax;
    ax   = $signed({a[VAL_WIDTH-1], a});
    bx   = $signed({b[VAL_WIDTH-1], b});
    pmax = $signed({1'b0, SMAX});
    nmax = -pmax;
    s    = sub ? (ax - bx) : (ax + bx);
    if (s > pmax) begin
      return SMAX;
    end else if (s < nmax) begin
      return nmax[VAL_WIDTH-1:0];
    end
    return s[VAL_WIDTH-1:0];
  endfunction

endpackage

### sv/stch_ram.sv
// generic register-file memory, one write port and two registered read ports
module stch_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

### sv/segment_triangle_closest_hit.sv
// segment against triangle stream, nearest hit, on a microcoded shared datapath
//
//  port group   direction  handshake                 payload
//  in_*         in         in_valid_i / in_stall_o   tri_t: three vertices, last_tri
//  out_*        out        out_valid_o / out_stall_i result_t: hit, point, min_dist_sq
//  cfg_*        in         cfg_we_i                  cfg_idx_i, cfg_data_i
//
// one triangle runs a 122-step program of simple steps, multiplies (four 32x32
// partial products) and divides (one quotient bit per cycle); an early reject
// ends the program before its last step.
// in_stall_o is high from acceptance until the program ends; a last triangle
// waits there while a previous result is still stalled at the output.
// reset clears the state, the segment to zero and the limit to 1000.0
module segment_triangle_closest_hit
  import stch_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  tri_t                      in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output result_t                   out_data_o,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_data_i
);

  state_e                  state_q, state_d;
  logic [PC_WIDTH-1:0]     pc_q, pc_d;
  tri_t                    in_q, in_d;
  logic [COORD_WIDTH-1:0]  seg_q [NUM_SEG_REGS];
  logic [COORD_WIDTH-1:0]  seg_d [NUM_SEG_REGS];
  logic [DIST_WIDTH-1:0]   limit_q, limit_d;
  logic [DIST_WIDTH-1:0]   best_dist_q, best_dist_d;
  logic [COORD_WIDTH-1:0]  best_p_q [3];
  logic [COORD_WIDTH-1:0]  best_p_d [3];
  logic                    found_q, found_d;
  logic                    upd_q, upd_d;
  logic                    out_valid_q, out_valid_d;
  result_t                 out_q, out_d;
  logic [VAL_WIDTH-1:0]    ma_q, ma_d, mb_q, mb_d;
  logic [PROD_WIDTH-1:0]   acc_q, acc_d;
  logic                    neg_q, neg_d;
  logic [DIV_STEPS-1:0]    nq_q, nq_d;
  logic [VAL_WIDTH-1:0]    den_q, den_d;
  logic [VAL_WIDTH-1:0]    rem_q, rem_d;
  logic [CNT_WIDTH-1:0]    cnt_q, cnt_d;

  uinstr_t                 ui;
  logic [VAL_WIDTH-1:0]    rd_a, rd_b;
  logic                    rf_we;
  logic [VAL_WIDTH-1:0]    rf_wdata;
  logic [VAL_WIDTH-1:0]    alu_res;
  logic [VAL_WIDTH-1:0]    ld_val;
  logic [HALF_WIDTH-1:0]   mul_ha, mul_hb;
  logic [VAL_WIDTH-1:0]    pp;
  logic [PROD_WIDTH-1:0]   pp_sh;
  logic [VAL_WIDTH-1:0]    mul_mag, mul_res;
  logic [VAL_WIDTH-1:0]    div_mag, div_res;
  logic [VAL_WIDTH:0]      trial;
  logic                    trial_ge;
  logic [DIST_WIDTH-1:0]   restart_lim;
  logic                    restart;

  assign ui = ucode(pc_q);

  stch_ram #(
    .WIDTH (VAL_WIDTH),
    .DEPTH (RF_DEPTH)
  ) u_rf (
    .clk_i     (clk_i),
    .we_i      (rf_we),
    .waddr_i   (ui.dst),
    .wdata_i   (rf_wdata),
    .raddr_a_i (ui.a),
    .raddr_b_i (ui.b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // operand sources for the load step
  always_comb begin
    case (ui.a[3:0])
      4'd0:    ld_val = VAL_WIDTH'(in_q.v0_x);
      4'd1:    ld_val = VAL_WIDTH'(in_q.v0_y);
      4'd2:    ld_val = VAL_WIDTH'(in_q.v0_z);
      4'd3:    ld_val = VAL_WIDTH'(in_q.v1_x);
      4'd4:    ld_val = VAL_WIDTH'(in_q.v1_y);
      4'd5:    ld_val = VAL_WIDTH'(in_q.v1_z);
      4'd6:    ld_val = VAL_WIDTH'(in_q.v2_x);
      4'd7:    ld_val = VAL_WIDTH'(in_q.v2_y);
      4'd8:    ld_val = VAL_WIDTH'(in_q.v2_z);
      4'd9:    ld_val = VAL_WIDTH'($signed(seg_q[0]));
      4'd10:   ld_val = VAL_WIDTH'($signed(seg_q[1]));
      4'd11:   ld_val = VAL_WIDTH'($signed(seg_q[2]));
      4'd12:   ld_val = VAL_WIDTH'($signed(seg_q[3]));
      4'd13:   ld_val = VAL_WIDTH'($signed(seg_q[4]));
      4'd14:   ld_val = VAL_WIDTH'($signed(seg_q[5]));
      default: ld_val = ONE_Q;
    endcase
  end

  // shared multiply: one partial product per cycle
  always_comb begin
    mul_ha = cnt_q[1] ? ma_q[VAL_WIDTH-1:HALF_WIDTH] : ma_q[HALF_WIDTH-1:0];
    mul_hb = cnt_q[0] ? mb_q[VAL_WIDTH-1:HALF_WIDTH] : mb_q[HALF_WIDTH-1:0];
    pp     = mul_ha * mul_hb;
    case (cnt_q[1:0])
      2'd0:    pp_sh = PROD_WIDTH'(pp);
      2'd3:    pp_sh = PROD_WIDTH'(pp) << VAL_WIDTH;
      default: pp_sh = PROD_WIDTH'(pp) << HALF_WIDTH;
    endcase
    if (|acc_q[PROD_WIDTH-1:VAL_WIDTH-1+FRAC_BITS]) begin
      mul_mag = SMAX;
    end else begin
      mul_mag = {1'b0, acc_q[VAL_WIDTH-2+FRAC_BITS:FRAC_BITS]};
    end
    mul_res = neg_q ? (~mul_mag + VAL_WIDTH'(1)) : mul_mag;
  end

  // restoring divide: quotient bits shift into the numerator register
  always_comb begin
    trial    = {rem_q, nq_q[DIV_STEPS-1]};
    trial_ge = trial >= {1'b0, den_q};
    if (|nq_q[DIV_STEPS-1:VAL_WIDTH-1]) begin
      div_mag = SMAX;
    end else begin
      div_mag = {1'b0, nq_q[VAL_WIDTH-2:0]};
    end
    if (den_q == '0) begin
      div_res = '0;
    end else begin
      div_res = neg_q ? (~div_mag + VAL_WIDTH'(1)) : div_mag;
    end
  end

  assign alu_res = sat_addsub(rd_a, rd_b, ui.op == OP_SUB);

  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    in_d        = in_q;
    seg_d       = seg_q;
    limit_d     = limit_q;
    best_dist_d = best_dist_q;
    best_p_d    = best_p_q;
    found_d     = found_q;
    upd_d       = upd_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ma_d        = ma_q;
    mb_d        = mb_q;
    acc_d       = acc_q;
    neg_d       = neg_q;
    nq_d        = nq_q;
    den_d       = den_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    rf_we       = 1'b0;
    rf_wdata    = alu_res;
    restart     = 1'b0;
    restart_lim = limit_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          in_d    = in_data_i;
          pc_d    = '0;
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        pc_d    = pc_q + PC_WIDTH'(1);
        state_d = ST_FETCH;
        case (ui.op)
          OP_LD: begin
            rf_we    = 1'b1;
            rf_wdata = ld_val;
          end
          OP_ADD, OP_SUB: begin
            rf_we = 1'b1;
          end
          OP_MUL: begin
            pc_d    = pc_q;
            ma_d    = mag(rd_a);
            mb_d    = mag(rd_b);
            neg_d   = rd_a[VAL_WIDTH-1] ^ rd_b[VAL_WIDTH-1];
            acc_d   = '0;
            cnt_d   = '0;
            state_d = ST_MUL;
          end
          OP_DIV: begin
            pc_d    = pc_q;
            nq_d    = {mag(rd_a), {FRAC_BITS{1'b0}}};
            den_d   = mag(rd_b);
            rem_d   = '0;
            neg_d   = rd_a[VAL_WIDTH-1] ^ rd_b[VAL_WIDTH-1];
            cnt_d   = CNT_WIDTH'(DIV_STEPS - 1);
            state_d = ST_DIV;
          end
          OP_CHKZ: begin
            if (rd_a == '0) begin
              state_d = ST_FIN;
            end
          end
          OP_CHKR: begin
            if (rd_a[VAL_WIDTH-1] || ($signed(rd_a) > $signed(ONE_Q))) begin
              state_d = ST_FIN;
            end
          end
          OP_CHKN: begin
            if (rd_a[VAL_WIDTH-1]) begin
              state_d = ST_FIN;
            end
          end
          OP_CMPD: begin
            upd_d = rd_a < VAL_WIDTH'(best_dist_q);
            if (rd_a < VAL_WIDTH'(best_dist_q)) begin
              best_dist_d = rd_a[DIST_WIDTH-1:0];
              found_d     = 1'b1;
            end
          end
          OP_SETP: begin
            if (upd_q) begin
              case (ui.dst[1:0])
                2'd0:    best_p_d[0] = rd_a[COORD_WIDTH-1:0];
                2'd1:    best_p_d[1] = rd_a[COORD_WIDTH-1:0];
                2'd2:    best_p_d[2] = rd_a[COORD_WIDTH-1:0];
                default: ;
              endcase
            end
          end
          default: begin
            pc_d    = pc_q;
            state_d = ST_FIN;
          end
        endcase
      end
      ST_MUL: begin
        acc_d = acc_q + pp_sh;
        cnt_d = cnt_q + CNT_WIDTH'(1);
        if (cnt_q[1:0] == 2'd3) begin
          state_d = ST_WB;
        end
      end
      ST_DIV: begin
        rem_d = trial_ge ? VAL_WIDTH'(trial - {1'b0, den_q}) : VAL_WIDTH'(trial);
        nq_d  = {nq_q[DIV_STEPS-2:0], trial_ge};
        cnt_d = cnt_q - CNT_WIDTH'(1);
        if (cnt_q == '0) begin
          state_d = ST_WB;
        end
      end
      ST_WB: begin
        rf_we    = 1'b1;
        rf_wdata = (ui.op == OP_MUL) ? mul_res : div_res;
        pc_d     = pc_q + PC_WIDTH'(1);
        state_d  = ST_FETCH;
      end
      ST_FIN: begin
        if (!in_q.last_tri) begin
          state_d = ST_IDLE;
        end else if (!out_valid_q || !out_stall_i) begin
          out_d.hit         = found_q;
          out_d.point_x     = best_p_q[0];
          out_d.point_y     = best_p_q[1];
          out_d.point_z     = best_p_q[2];
          out_d.min_dist_sq = best_dist_q;
          out_valid_d       = 1'b1;
          restart           = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      restart = 1'b1;
      case (cfg_idx_e'(cfg_idx_i))
        CFG_START_X: seg_d[0] = cfg_data_i[COORD_WIDTH-1:0];
        CFG_START_Y: seg_d[1] = cfg_data_i[COORD_WIDTH-1:0];
        CFG_START_Z: seg_d[2] = cfg_data_i[COORD_WIDTH-1:0];
        CFG_END_X:   seg_d[3] = cfg_data_i[COORD_WIDTH-1:0];
        CFG_END_Y:   seg_d[4] = cfg_data_i[COORD_WIDTH-1:0];
        CFG_END_Z:   seg_d[5] = cfg_data_i[COORD_WIDTH-1:0];
        CFG_LIMIT: begin
          limit_d     = cfg_data_i[DIST_WIDTH-1:0];
          restart_lim = cfg_data_i[DIST_WIDTH-1:0];
        end
        default: restart = 1'b0;
      endcase
    end

    if (restart) begin
      best_dist_d = restart_lim;
      best_p_d[0] = '0;
      best_p_d[1] = '0;
      best_p_d[2] = '0;
      found_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= '0;
      seg_q[0]    <= '0;
      seg_q[1]    <= '0;
      seg_q[2]    <= '0;
      seg_q[3]    <= '0;
      seg_q[4]    <= '0;
      seg_q[5]    <= '0;
      limit_q     <= DIST_RESET;
      best_dist_q <= DIST_RESET;
      best_p_q[0] <= '0;
      best_p_q[1] <= '0;
      best_p_q[2] <= '0;
      found_q     <= 1'b0;
      upd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      seg_q       <= seg_d;
      limit_q     <= limit_d;
      best_dist_q <= best_dist_d;
      best_p_q    <= best_p_d;
      found_q     <= found_d;
      upd_q       <= upd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    out_q <= out_d;
    ma_q  <= ma_d;
    mb_q  <= mb_d;
    acc_q <= acc_d;
    neg_q <= neg_d;
    nq_q  <= nq_d;
    den_q <= den_d;
    rem_q <= rem_d;
    cnt_q <= cnt_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // a new result only comes out of the finishing step
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_FIN))
    else $error("result raised outside the finishing step");

  // with a hit the kept distance is strictly under the limit
  a_found_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> (best_dist_q < limit_q))
    else $error("kept distance not below the limit");

  // with no hit the kept state is the restart value
  a_nohit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !found_q |-> (best_dist_q == limit_q) && (best_p_q[0] == '0) &&
                 (best_p_q[1] == '0) && (best_p_q[2] == '0))
    else $error("kept point or distance changed without a hit");

  // the sequencer never runs past the end of its program
  a_pc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (pc_q <= UC_LAST))
    else $error("program counter out of range");
`endif

endmodule
